FILE: rtl/core/rbp_pkg.sv
// Shared constants and types for the RISC-V branch predecoder.
package rbp_pkg;

  localparam int FieldW      = 39;
  localparam int InstrW      = 32;
  localparam int OffW        = 21;
  localparam int DefAddrBits = 39;
  localparam int PcStep      = 4;

  localparam logic [6:0]  OpJal    = 7'h6F;
  localparam logic [6:0]  OpBranch = 7'h63;
  localparam logic [2:0]  CjFunct3 = 3'h5;
  localparam logic [1:0]  CQuad1   = 2'h1;
  localparam logic [15:0] CRetWord = 16'h8082;

  // Decode result: jump seen, target is the return address, signed PC offset.
  typedef struct packed {
    logic            jump;
    logic            ret;
    logic [OffW-1:0] off;
  } dec_t;

endpackage

FILE: rtl/core/riscv_branch_predecoder_core.sv
// Top level of the static RISC-V branch predecoder, three register stages.
// Predicts the next fetch address from one fetched word: JAL, a backward
// conditional branch, C.J and C.RET (the last two only with compressed_ok_i
// set), in that priority; otherwise the fetch address plus 4. Address sums
// wrap at min(ADDR_BITS, 39) bits. One transaction is accepted per cycle
// while stall_o is low; a result passes through three registers (decode,
// address add, target select), and a stall on the output backs up only the
// stages that hold data, so bubbles are absorbed.
module riscv_branch_predecoder_core #(
  parameter int ADDR_BITS = rbp_pkg::DefAddrBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic                       compressed_ok_i,
  input  logic [rbp_pkg::FieldW-1:0] fetch_addr_i,
  input  logic [rbp_pkg::InstrW-1:0] instr_word_i,
  input  logic [rbp_pkg::FieldW-1:0] return_addr_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic                       jump_found_o,
  output logic [rbp_pkg::FieldW-1:0] cur_pc_o,
  output logic [rbp_pkg::FieldW-1:0] next_pc_o
);
  import rbp_pkg::*;

  localparam int AddrW = (ADDR_BITS < FieldW) ? ADDR_BITS : FieldW;

  dec_t dec;

  logic             v1_q, v2_q, v3_q;
  logic             ready1, ready2, ready3;
  dec_t             dec1_q;
  logic [AddrW-1:0] pc1_q, ra1_q;
  logic             jump2_q, ret2_q;
  logic [AddrW-1:0] pc2_q, ra2_q, sum2_q;
  logic [AddrW-1:0] sum2_d;
  logic             jump3_q;
  logic [AddrW-1:0] pc3_q, next3_q;

  rbp_predecode u_predecode (
    .instr_word_i    (instr_word_i),
    .compressed_ok_i (compressed_ok_i),
    .dec_o           (dec)
  );

  assign ready3  = !v3_q || !stall_i;
  assign ready2  = !v2_q || ready3;
  assign ready1  = !v1_q || ready2;
  assign stall_o = !ready1;

  assign sum2_d = pc1_q + AddrW'($signed(dec1_q.off));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= valid_i;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && valid_i) begin
      dec1_q <= dec;
      pc1_q  <= fetch_addr_i[AddrW-1:0];
      ra1_q  <= return_addr_i[AddrW-1:0];
    end
    if (ready2 && v1_q) begin
      jump2_q <= dec1_q.jump;
      ret2_q  <= dec1_q.ret;
      pc2_q   <= pc1_q;
      ra2_q   <= ra1_q;
      sum2_q  <= sum2_d;
    end
    if (ready3 && v2_q) begin
      jump3_q <= jump2_q;
      pc3_q   <= pc2_q;
      next3_q <= ret2_q ? ra2_q : sum2_q;
    end
  end

  assign valid_o      = v3_q;
  assign jump_found_o = jump3_q;
  assign cur_pc_o     = FieldW'(pc3_q);
  assign next_pc_o    = FieldW'(next3_q);

`ifndef SYNTHESIS
  a_no_jump_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !jump_found_o) |->
      (next_pc_o[AddrW-1:0] == cur_pc_o[AddrW-1:0] + AddrW'(PcStep)))
    else $error("sequential next_pc mismatch");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && stall_i) |-> stall_o)
    else $error("full pipeline not stalling input");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> v1_q)
    else $error("accepted transaction lost in stage 1");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !ready3) |=> v2_q)
    else $error("stage 2 dropped under stall");
`endif

endmodule

FILE: rtl/core/rbp_predecode.sv
// Instruction pattern match and immediate rebuild for the branch predecoder.
module rbp_predecode (
  input  logic [rbp_pkg::InstrW-1:0] instr_word_i,
  input  logic                       compressed_ok_i,
  output rbp_pkg::dec_t              dec_o
);
  import rbp_pkg::*;

  logic            is_jal, is_br, is_cj, is_ret;
  logic [20:0]     jal_raw;
  logic [12:0]     br_raw;
  logic [11:0]     cj_raw;
  logic [OffW-1:0] jal_off, br_off, cj_off;

  assign jal_raw = {instr_word_i[31], instr_word_i[19:12], instr_word_i[20],
                    instr_word_i[30:21], 1'b0};
  assign br_raw  = {instr_word_i[31], instr_word_i[7], instr_word_i[30:25],
                    instr_word_i[11:8], 1'b0};
  assign cj_raw  = {instr_word_i[12], instr_word_i[8], instr_word_i[10:9],
                    instr_word_i[6], instr_word_i[7], instr_word_i[2],
                    instr_word_i[11], instr_word_i[5:3], 1'b0};

  assign jal_off = OffW'($signed(jal_raw));
  assign br_off  = OffW'($signed(br_raw));
  assign cj_off  = OffW'($signed(cj_raw));

  assign is_jal = (instr_word_i[6:0] == OpJal);
  assign is_br  = (instr_word_i[6:0] == OpBranch) && instr_word_i[31];
  assign is_cj  = (instr_word_i[15:13] == CjFunct3) && (instr_word_i[1:0] == CQuad1)
                  && compressed_ok_i;
  assign is_ret = (instr_word_i[15:0] == CRetWord) && compressed_ok_i;

  always_comb begin
    dec_o.jump = is_jal || is_br || is_cj || is_ret;
    dec_o.ret  = 1'b0;
    if (is_jal) begin
      dec_o.off = jal_off;
    end else if (is_br) begin
      dec_o.off = br_off;
    end else if (is_cj) begin
      dec_o.off = cj_off;
    end else begin
      dec_o.off = OffW'(PcStep);
      dec_o.ret = is_ret;
    end
  end

endmodule

FILE: verif/riscv_branch_predecoder_core_tb.sv
// Self-checking testbench for the RISC-V static branch predecoder core.
module riscv_branch_predecoder_core_tb;
  import rbp_pkg::*;

  localparam int ItemCount = 1050;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 12;
  localparam logic [FieldW-1:0] AddrTop = '1;

  typedef enum int {HitSeq, HitJal, HitBranch, HitCj, HitRet} fetch_kind_e;

  typedef struct packed {
    logic              jump;
    logic [FieldW-1:0] cur;
    logic [FieldW-1:0] nxt;
  } fetch_result_t;

  class fetch_scoreboard;
    fetch_result_t expected_q[$];
    int            errors;
    int            checked;
    int            kind_count[5];

    // Next-PC prediction: JAL, backward branch, C.J, RET, else PC + 4.
    function fetch_result_t predict_target(logic cok, logic [FieldW-1:0] pc,
                                           logic [InstrW-1:0] w,
                                           logic [FieldW-1:0] ra);
      logic [FieldW-1:0] jal_off, br_off, cj_off;
      fetch_result_t     res;
      jal_off = {{(FieldW-21){w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      br_off  = {{(FieldW-13){w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      cj_off  = {{(FieldW-12){w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2],
                 w[11], w[5:3], 1'b0};
      res.cur  = pc;
      res.jump = 1'b1;
      if (w[6:0] == OpJal) begin
        res.nxt = pc + jal_off;
        kind_count[HitJal]++;
      end else if (w[6:0] == OpBranch && w[31]) begin
        res.nxt = pc + br_off;
        kind_count[HitBranch]++;
      end else if (w[15:13] == CjFunct3 && w[1:0] == CQuad1 && cok) begin
        res.nxt = pc + cj_off;
        kind_count[HitCj]++;
      end else if (w[15:0] == CRetWord && cok) begin
        res.nxt = ra;
        kind_count[HitRet]++;
      end else begin
        res.nxt  = pc + FieldW'(PcStep);
        res.jump = 1'b0;
        kind_count[HitSeq]++;
      end
      return res;
    endfunction

    function void note_fetch(logic cok, logic [FieldW-1:0] pc, logic [InstrW-1:0] w,
                             logic [FieldW-1:0] ra);
      expected_q.push_back(predict_target(cok, pc, w, ra));
    endfunction

    function void check_result(logic jump, logic [FieldW-1:0] cur,
                               logic [FieldW-1:0] nxt);
      fetch_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result jump=%0b cur=%h next=%h", $time, jump, cur, nxt);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (jump !== exp_r.jump) begin
        $display("%0t: jump_found expected %0b actual %0b", $time, exp_r.jump, jump);
        errors++;
      end
      if (cur !== exp_r.cur) begin
        $display("%0t: cur_pc expected %h actual %h", $time, exp_r.cur, cur);
        errors++;
      end
      if (nxt !== exp_r.nxt) begin
        $display("%0t: next_pc expected %h actual %h", $time, exp_r.nxt, nxt);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              valid_i;
  logic              stall_o;
  logic              compressed_ok_i;
  logic [FieldW-1:0] fetch_addr_i;
  logic [InstrW-1:0] instr_word_i;
  logic [FieldW-1:0] return_addr_i;
  logic              valid_o;
  logic              stall_i;
  logic              jump_found_o;
  logic [FieldW-1:0] cur_pc_o;
  logic [FieldW-1:0] next_pc_o;

  fetch_scoreboard sb = new();
  int              quiet_cycles;
  int              stall_phase;
  int              stall_mode;

  riscv_branch_predecoder_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .compressed_ok_i (compressed_ok_i),
    .fetch_addr_i    (fetch_addr_i),
    .instr_word_i    (instr_word_i),
    .return_addr_i   (return_addr_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .jump_found_o    (jump_found_o),
    .cur_pc_o        (cur_pc_o),
    .next_pc_o       (next_pc_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Transaction monitors on both channels.
  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o)
      sb.note_fetch(compressed_ok_i, fetch_addr_i, instr_word_i, return_addr_i);
    if (rst_ni && valid_o && !stall_i)
      sb.check_result(jump_found_o, cur_pc_o, next_pc_o);
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure in one of four randomly chosen stall modes.
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
    case (stall_mode)
      0: stall_i <= 1'b0;
      1: stall_i <= ($urandom_range(0, 3) == 0);
      2: stall_i <= ($urandom_range(0, 1) == 0);
      default: stall_i <= stall_phase[3];
    endcase
  end

  task automatic send_fetch(input logic cok, input logic [FieldW-1:0] pc,
                            input logic [InstrW-1:0] w, input logic [FieldW-1:0] ra);
    valid_i         <= 1'b1;
    compressed_ok_i <= cok;
    fetch_addr_i    <= pc;
    instr_word_i    <= w;
    return_addr_i   <= ra;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    valid_i      <= 1'b0;
    instr_word_i <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic [FieldW-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return AddrTop - FieldW'(r[7:0]);
      1: return FieldW'(r[7:0]);
      default: return r[FieldW-1:0];
    endcase
  endfunction

  function automatic logic [InstrW-1:0] rand_word();
    logic [InstrW-1:0] w;
    int                flip_bit;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1: w[6:0] = OpJal;
      2, 3: w[6:0] = OpBranch;
      4, 5: begin
        w[15:13] = CjFunct3;
        w[1:0]   = CQuad1;
      end
      6: w[15:0] = CRetWord;
      7: begin
        // a recognized encoding with one of its low 16 bits flipped
        case ($urandom_range(0, 3))
          0: w[6:0] = OpJal;
          1: w[6:0] = OpBranch;
          2: begin
            w[15:13] = CjFunct3;
            w[1:0]   = CQuad1;
          end
          default: w[15:0] = CRetWord;
        endcase
        flip_bit = $urandom_range(0, 15);
        w[flip_bit] = ~w[flip_bit];
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    int burst_left;
    int gap;
    rst_ni          <= 1'b0;
    valid_i         <= 1'b0;
    compressed_ok_i <= 1'b0;
    fetch_addr_i    <= '0;
    instr_word_i    <= '0;
    return_addr_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: encodings at their offset extremes, wrap at both ends.
    send_fetch(1'b0, '0, '0, '0);
    send_fetch(1'b1, AddrTop, '1, AddrTop);
    send_fetch(1'b1, AddrTop, {1'b0, 10'h3FF, 1'b1, 8'hFF, 5'h01, OpJal}, '0);
    send_fetch(1'b1, '0, {1'b1, 10'h000, 1'b0, 8'h00, 5'h00, OpJal}, '0);
    send_fetch(1'b0, 39'h40, {1'b1, 10'h3FF, 1'b1, 8'hFF, 5'h1F, OpJal}, '0);
    send_fetch(1'b1, '0, {1'b1, 6'h00, 5'h00, 5'h00, 3'h0, 4'h0, 1'b0, OpBranch}, '0);
    send_fetch(1'b1, 39'h1000,
               {1'b1, 6'h3F, 5'h1F, 5'h1F, 3'h7, 4'hF, 1'b1, OpBranch}, '0);
    send_fetch(1'b1, AddrTop,
               {1'b0, 6'h3F, 5'h1F, 5'h1F, 3'h7, 4'hF, 1'b1, OpBranch}, '0);
    send_fetch(1'b1, AddrTop, {16'h0000, 16'hAFFD}, '0);
    send_fetch(1'b1, '0, {16'hFFFF, 16'hB001}, '0);
    send_fetch(1'b1, 39'h800, {16'h1234, 16'hBFFD}, '0);
    send_fetch(1'b0, 39'h800, {16'h1234, 16'hAFFD}, '0);
    send_fetch(1'b1, 39'h2000, {16'h0000, CRetWord}, AddrTop);
    send_fetch(1'b1, 39'h2000, {16'hFFFF, CRetWord}, '0);
    send_fetch(1'b0, 39'h2000, {16'h0000, CRetWord}, AddrTop);
    send_fetch(1'b1, AddrTop - 39'd3, 32'h0000_0013, 39'h5A5A5A5A5A);
    send_fetch(1'b1, 39'h2AAAAAAAAA, 32'hAAAA_AAAA, 39'h2AAAAAAAAA);
    send_fetch(1'b1, 39'h5555555555, 32'h5555_5555, 39'h5555555555);

    burst_left = 0;
    for (int n = 18; n < ItemCount; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) idle_sender(gap);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      send_fetch(($urandom_range(0, 3) != 0), rand_addr(), rand_word(), rand_addr());
    end
    valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d predictions: %0d JAL, %0d backward branch, %0d C.J, %0d RET,",
             sb.checked, sb.kind_count[HitJal], sb.kind_count[HitBranch],
             sb.kind_count[HitCj], sb.kind_count[HitRet]);
    $display("%0d sequential, under random sender gaps and receiver stalls.",
             sb.kind_count[HitSeq]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rbp_pkg.sv
rtl/core/rbp_predecode.sv
rtl/core/riscv_branch_predecoder_core.sv
verif/riscv_branch_predecoder_core_tb.sv
